@@ design/fgn_pkg.sv @@
package fgn_pkg;

    localparam int OUT_W     = 18;
    localparam int OUT_FRAC  = 16;
    localparam int OUT_MAX   = 131071;
    localparam int OUT_MIN   = -131072;
    localparam int GRAD_BITS = 15;
    localparam int GRAD_W    = 17;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COUNT_W    = 4;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd1;
    localparam logic REG_OCTAVE_COUNT = 1'b0;

    localparam logic [31:0] HASH_K1 = 32'd3284157443;
    localparam logic [31:0] HASH_K2 = 32'd1911520717;
    localparam logic [31:0] HASH_K3 = 32'd2048419325;

    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_t;

    function automatic logic [31:0] rot16(input logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

    // One quarter-turn gradient entry: {cos, sin} in Q1.15, unsigned.
    function automatic logic [31:0] grad_entry(input int j, input int bits);
        logic [63:0] n;
        logic [63:0] jj;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] sq;
        logic [63:0] cq;
        logic [63:0] c;
        logic [63:0] s;
        n  = 64'd1 << bits;
        jj = 64'(j);
        if (jj <= (n >> 3))
            x = (jj * TWO_PI_Q30) >> bits;
        else
            x = (((n >> 2) - jj) * TWO_PI_Q30) >> bits;
        x2 = (x * x + (Q30_ONE >> 1)) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 156;
        t  = Q30_ONE - ((x2 * t) >> 30) / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        sq = (x * t) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 132;
        t  = Q30_ONE - ((x2 * t) >> 30) / 90;
        t  = Q30_ONE - ((x2 * t) >> 30) / 56;
        t  = Q30_ONE - ((x2 * t) >> 30) / 30;
        t  = Q30_ONE - ((x2 * t) >> 30) / 12;
        t  = Q30_ONE - ((x2 * t) >> 30) / 2;
        cq = t;
        if (jj <= (n >> 3))
        begin
            c = (cq + (64'd1 << 14)) >> 15;
            s = (sq + (64'd1 << 14)) >> 15;
        end
        else
        begin
            c = (sq + (64'd1 << 14)) >> 15;
            s = (cq + (64'd1 << 14)) >> 15;
        end
        return {c[15:0], s[15:0]};
    endfunction

endpackage

@@ design/fgn_fade.sv @@
module fgn_fade #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 adv,
    input  logic [FRAC_BITS-1:0] t,
    output logic [FRAC_BITS:0]   s
);
    localparam int F  = FRAC_BITS;
    localparam int WW = F + 6;
    localparam int PW = WW + F + 1;
    localparam logic signed [WW-1:0] ONE_W = WW'(1) <<< F;

    function automatic logic signed [WW-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] q;
        q = (p + (PW'(1) <<< (F - 1))) >>> F;
        return WW'(q);
    endfunction

    logic signed [F:0]    t_s;
    logic signed [WW-1:0] lin;
    logic signed [WW-1:0] w1;
    logic signed [WW-1:0] w4;
    logic signed [F:0]    t1_reg, t2_reg, t3_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [PW-1:0] p1_next, p2_next, p3_next, p4_next;
    logic [F:0]           s_reg, s_next;

    assign t_s = signed'({1'b0, t});

    always_comb
    begin
        lin     = WW'(WW'(t_s) * 6 - ONE_W * 15);
        p1_next = PW'(t_s) * PW'(lin);
        w1      = WW'(rnd(p1_reg) + ONE_W * 10);
        p2_next = PW'(w1) * PW'(t1_reg);
        p3_next = PW'(rnd(p2_reg)) * PW'(t2_reg);
        p4_next = PW'(rnd(p3_reg)) * PW'(t3_reg);
        w4      = rnd(p4_reg);
        if (w4 < 0)
            s_next = '0;
        else if (w4 > ONE_W)
            s_next = (F+1)'(ONE_W);
        else
            s_next = (F+1)'(w4);
    end

    // payload only: advance with the pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= p1_next;
            t1_reg <= t_s;
            p2_reg <= p2_next;
            t2_reg <= t1_reg;
            p3_reg <= p3_next;
            t3_reg <= t2_reg;
            p4_reg <= p4_next;
            s_reg  <= s_next;
        end
    end

    assign s = s_reg;

endmodule

@@ design/fgn_corner.sv @@
module fgn_corner #(
    parameter int ANGLE_TABLE_BITS = 10,
    parameter int FRAC_BITS        = 16
) (
    input  logic                      clk,
    input  logic                      adv,
    input  logic [31:0]               cx,
    input  logic [31:0]               cy,
    input  logic signed [FRAC_BITS:0] dx,
    input  logic signed [FRAC_BITS:0] dy,
    output logic signed [FRAC_BITS+2:0] dot
);
    import fgn_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int ATB  = ANGLE_TABLE_BITS;
    localparam int JW   = ATB - 2;
    localparam int QN   = 1 << JW;
    localparam int PW   = GRAD_W + F + 1;
    localparam int SW   = PW + 1;
    localparam int DOTW = F + 3;

    logic [31:0] grad_rom [QN];

    for (genvar j = 0; j < QN; j++)
    begin : g_rom
        localparam logic [31:0] ENTRY = grad_entry(j, ATB);
        assign grad_rom[j] = ENTRY;
    end

    logic [31:0]              a1_reg, cy1_reg, a2_reg, b2_reg, h3_reg;
    logic signed [F:0]        dx1_reg, dy1_reg, dx2_reg, dy2_reg, dx3_reg, dy3_reg;
    logic signed [F:0]        dx4_reg, dy4_reg;
    logic signed [GRAD_W-1:0] gx4_reg, gy4_reg, gx_next, gy_next;
    logic signed [PW-1:0]     px5_reg, py5_reg;
    logic signed [DOTW-1:0]   dot6_reg;
    logic [ATB-1:0]           k;
    logic [31:0]              entry;
    logic signed [GRAD_W-1:0] c_g, s_g;
    logic signed [SW-1:0]     sum;

    always_comb
    begin
        k     = h3_reg[31 -: ATB];
        entry = grad_rom[k[JW-1:0]];
        c_g   = signed'({1'b0, entry[31:16]});
        s_g   = signed'({1'b0, entry[15:0]});
        case (quad_t'(k[ATB-1 -: 2]))
            QUAD_I:
            begin
                gx_next = c_g;
                gy_next = s_g;
            end
            QUAD_II:
            begin
                gx_next = -s_g;
                gy_next = c_g;
            end
            QUAD_III:
            begin
                gx_next = -c_g;
                gy_next = -s_g;
            end
            QUAD_IV:
            begin
                gx_next = s_g;
                gy_next = -c_g;
            end
            default:
            begin
                gx_next = s_g;
                gy_next = -c_g;
            end
        endcase
        sum = SW'(px5_reg) + SW'(py5_reg) + (SW'(1) <<< (GRAD_BITS - 1));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg   <= 32'(cx * HASH_K1);
            cy1_reg  <= cy;
            dx1_reg  <= dx;
            dy1_reg  <= dy;
            a2_reg   <= a1_reg;
            b2_reg   <= 32'((cy1_reg ^ rot16(a1_reg)) * HASH_K2);
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            h3_reg   <= 32'((a2_reg ^ rot16(b2_reg)) * HASH_K3);
            dx3_reg  <= dx2_reg;
            dy3_reg  <= dy2_reg;
            gx4_reg  <= gx_next;
            gy4_reg  <= gy_next;
            dx4_reg  <= dx3_reg;
            dy4_reg  <= dy3_reg;
            px5_reg  <= PW'(gx4_reg) * PW'(dx4_reg);
            py5_reg  <= PW'(gy4_reg) * PW'(dy4_reg);
            dot6_reg <= DOTW'(sum >>> GRAD_BITS);
        end
    end

    assign dot = dot6_reg;

endmodule

@@ design/fgn_cell.sv @@
module fgn_cell #(
    parameter int OCTAVE           = 0,
    parameter int MAX_OCTAVES      = 8,
    parameter int ANGLE_TABLE_BITS = 10,
    parameter int FRAC_BITS        = 16,
    parameter int ACC_W            = 28
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    active,
    input  logic                    up_valid,
    input  logic [31:0]             up_x,
    input  logic [31:0]             up_y,
    input  logic signed [ACC_W-1:0] up_acc,
    output logic                    dn_valid,
    output logic [31:0]             dn_x,
    output logic [31:0]             dn_y,
    output logic signed [ACC_W-1:0] dn_acc
);
    localparam int F     = FRAC_BITS;
    localparam int DOTW  = F + 3;
    localparam int BW    = 2 * F + 6;
    localparam int DEPTH = 9;
    localparam int WSH   = MAX_OCTAVES - OCTAVE;

    function automatic logic signed [BW-1:0] rnd(input logic signed [BW-1:0] p);
        return (p + (BW'(1) <<< (F - 1))) >>> F;
    endfunction

    logic                    v0_reg;
    logic [31:0]             x0_reg, y0_reg;
    logic signed [ACC_W-1:0] acc0_reg;
    logic                    v_pipe_reg   [DEPTH];
    logic [31:0]             x_pipe_reg   [DEPTH];
    logic [31:0]             y_pipe_reg   [DEPTH];
    logic signed [ACC_W-1:0] acc_pipe_reg [DEPTH];

    logic [31:0]          cx, cy, cx1, cy1;
    logic signed [F:0]    dxl, dxh, dyl, dyh;
    logic signed [DOTW-1:0] d00, d01, d10, d11;
    logic [F:0]           sx, sy;
    logic [F:0]           sx6_reg, sy6_reg, sy7_reg, sy8_reg;
    logic signed [BW-1:0] lo7_reg, hi7_reg, py9_reg;
    logic signed [DOTW-1:0] d00_7_reg, d01_7_reg, l0_8_reg, l1_8_reg, l0_9_reg;
    logic signed [DOTW-1:0] v_oct;
    logic signed [ACC_W-1:0] contrib;

    // split into cell and fraction; the upper corner wraps with the 32-bit add
    assign cx  = 32'($signed(x0_reg) >>> F);
    assign cy  = 32'($signed(y0_reg) >>> F);
    assign cx1 = cx + 32'd1;
    assign cy1 = cy + 32'd1;
    assign dxl = signed'({1'b0, x0_reg[F-1:0]});
    assign dxh = signed'({1'b1, x0_reg[F-1:0]});
    assign dyl = signed'({1'b0, y0_reg[F-1:0]});
    assign dyh = signed'({1'b1, y0_reg[F-1:0]});

    fgn_corner #(.ANGLE_TABLE_BITS(ANGLE_TABLE_BITS), .FRAC_BITS(FRAC_BITS)) u_c00 (
        .clk(clk), .adv(adv), .cx(cx), .cy(cy), .dx(dxl), .dy(dyl), .dot(d00));
    fgn_corner #(.ANGLE_TABLE_BITS(ANGLE_TABLE_BITS), .FRAC_BITS(FRAC_BITS)) u_c01 (
        .clk(clk), .adv(adv), .cx(cx), .cy(cy1), .dx(dxl), .dy(dyh), .dot(d01));
    fgn_corner #(.ANGLE_TABLE_BITS(ANGLE_TABLE_BITS), .FRAC_BITS(FRAC_BITS)) u_c10 (
        .clk(clk), .adv(adv), .cx(cx1), .cy(cy), .dx(dxh), .dy(dyl), .dot(d10));
    fgn_corner #(.ANGLE_TABLE_BITS(ANGLE_TABLE_BITS), .FRAC_BITS(FRAC_BITS)) u_c11 (
        .clk(clk), .adv(adv), .cx(cx1), .cy(cy1), .dx(dxh), .dy(dyh), .dot(d11));

    fgn_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
        .clk(clk), .adv(adv), .t(x0_reg[F-1:0]), .s(sx));
    fgn_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
        .clk(clk), .adv(adv), .t(y0_reg[F-1:0]), .s(sy));

    always_comb
    begin
        v_oct   = DOTW'(BW'(l0_9_reg) + rnd(py9_reg));
        contrib = active ? (ACC_W'(v_oct) <<< WSH) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            for (int i = 0; i < DEPTH; i++)
                v_pipe_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg        <= up_valid;
            v_pipe_reg[0] <= v0_reg;
            for (int i = 1; i < DEPTH; i++)
                v_pipe_reg[i] <= v_pipe_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg          <= up_x;
            y0_reg          <= up_y;
            acc0_reg        <= up_acc;
            x_pipe_reg[0]   <= x0_reg;
            y_pipe_reg[0]   <= y0_reg;
            acc_pipe_reg[0] <= acc0_reg;
            for (int i = 1; i < DEPTH; i++)
            begin
                x_pipe_reg[i]   <= x_pipe_reg[i-1];
                y_pipe_reg[i]   <= y_pipe_reg[i-1];
                acc_pipe_reg[i] <= acc_pipe_reg[i-1];
            end
            // line the fades up with the corner dots
            sx6_reg   <= sx;
            sy6_reg   <= sy;
            // blend along x
            lo7_reg   <= BW'(d10 - d00) * BW'(signed'({1'b0, sx6_reg}));
            hi7_reg   <= BW'(d11 - d01) * BW'(signed'({1'b0, sx6_reg}));
            d00_7_reg <= d00;
            d01_7_reg <= d01;
            sy7_reg   <= sy6_reg;
            l0_8_reg  <= DOTW'(BW'(d00_7_reg) + rnd(lo7_reg));
            l1_8_reg  <= DOTW'(BW'(d01_7_reg) + rnd(hi7_reg));
            sy8_reg   <= sy7_reg;
            // blend along y
            py9_reg   <= BW'(l1_8_reg - l0_8_reg) * BW'(signed'({1'b0, sy8_reg}));
            l0_9_reg  <= l0_8_reg;
        end
    end

    assign dn_valid = v_pipe_reg[DEPTH-1];
    assign dn_x     = {x_pipe_reg[DEPTH-1][30:0], 1'b0};
    assign dn_y     = {y_pipe_reg[DEPTH-1][30:0], 1'b0};
    assign dn_acc   = acc_pipe_reg[DEPTH-1] + contrib;

endmodule

@@ design/fractal_gradient_noise_top.sv @@
// Path: each point runs through every octave cell in order, then the output register.
// Throughput: one point per cycle; every octave cell is a fully pipelined 10-stage slice.
// The chain only halts while a finished result sits unaccepted and another one is behind it.
// Reset: rst_n is asynchronous, active low; it empties the pipeline and sets octave_count to 1.
module fractal_gradient_noise_top #(
    parameter int MAX_OCTAVES      = 8,
    parameter int ANGLE_TABLE_BITS = 10,
    parameter int FRAC_BITS        = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fgn_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [fgn_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [fgn_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    // point in
    input  logic                              pt_valid,
    output logic                              pt_stall,
    input  logic signed [31:0]                x_coord,
    input  logic signed [31:0]                y_coord,
    // noise out
    output logic                              noise_valid,
    input  logic                              noise_stall,
    output logic signed [fgn_pkg::OUT_W-1:0]  noise_value
);
    import fgn_pkg::*;

    // accumulator: one extra fraction bit per octave of weighting, plus headroom
    localparam int ACC_W = FRAC_BITS + MAX_OCTAVES + 4;
    localparam int SH    = MAX_OCTAVES + FRAC_BITS - OUT_FRAC;
    localparam int SW    = ACC_W + OUT_FRAC;
    localparam logic signed [SW-1:0] SAT_HI = SW'(OUT_MAX);
    localparam logic signed [SW-1:0] SAT_LO = SW'(OUT_MIN);

    logic [COUNT_W-1:0] octave_count_reg;
    logic               cfg_wr;
    logic               adv;

    // chain taps: index 0 is the incoming point, index MAX_OCTAVES leaves the last cell
    logic                    chain_valid [MAX_OCTAVES+1];
    logic [31:0]             chain_x     [MAX_OCTAVES+1];
    logic [31:0]             chain_y     [MAX_OCTAVES+1];
    logic signed [ACC_W-1:0] chain_acc   [MAX_OCTAVES+1];
    logic [MAX_OCTAVES-1:0]  active;

    logic                    last_valid;
    logic signed [SW-1:0]    scaled;
    logic signed [OUT_W-1:0] sat_value;
    logic                    noise_valid_reg;
    logic signed [OUT_W-1:0] noise_value_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            octave_count_reg <= COUNT_RESET;
        else if (cfg_wr && (paddr[CFG_ADDR_W-1] == REG_OCTAVE_COUNT))
            octave_count_reg <= pwdata[COUNT_W-1:0];
    end

    assign prdata = (paddr[CFG_ADDR_W-1] == REG_OCTAVE_COUNT) ?
                    CFG_DATA_W'(octave_count_reg) : '0;

    // ---------------- flow control ----------------
    // Advance the whole chain unless the output register holds an untaken
    // result and the last cell has another one ready behind it.
    assign last_valid = chain_valid[MAX_OCTAVES];
    assign adv        = !noise_valid_reg || !noise_stall || !last_valid;
    assign pt_stall   = !adv;

    // ---------------- octave chain ----------------
    assign chain_valid[0] = pt_valid;
    assign chain_x[0]     = x_coord;
    assign chain_y[0]     = y_coord;
    assign chain_acc[0]   = '0;

    for (genvar o = 0; o < MAX_OCTAVES; o++)
    begin : g_oct
        // octave counts above MAX_OCTAVES fall out of this compare on their own
        assign active[o] = int'(octave_count_reg) > o;

        fgn_cell #(
            .OCTAVE           (o),
            .MAX_OCTAVES      (MAX_OCTAVES),
            .ANGLE_TABLE_BITS (ANGLE_TABLE_BITS),
            .FRAC_BITS        (FRAC_BITS),
            .ACC_W            (ACC_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .active   (active[o]),
            .up_valid (chain_valid[o]),
            .up_x     (chain_x[o]),
            .up_y     (chain_y[o]),
            .up_acc   (chain_acc[o]),
            .dn_valid (chain_valid[o+1]),
            .dn_x     (chain_x[o+1]),
            .dn_y     (chain_y[o+1]),
            .dn_acc   (chain_acc[o+1])
        );
    end

    // ---------------- rescale to Q2.16 and saturate ----------------
    if (SH > 0)
    begin : g_round
        assign scaled = (SW'(chain_acc[MAX_OCTAVES]) + (SW'(1) <<< (SH - 1))) >>> SH;
    end
    else if (SH == 0)
    begin : g_keep
        assign scaled = SW'(chain_acc[MAX_OCTAVES]);
    end
    else
    begin : g_widen
        assign scaled = SW'(chain_acc[MAX_OCTAVES]) <<< (-SH);
    end

    always_comb
    begin
        if (scaled > SAT_HI)
            sat_value = OUT_W'(OUT_MAX);
        else if (scaled < SAT_LO)
            sat_value = OUT_W'(OUT_MIN);
        else
            sat_value = OUT_W'(scaled);
    end

    // ---------------- output register ----------------
    // Load whenever the held result is gone or being taken; otherwise hold.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            noise_valid_reg <= 1'b0;
        else if (!noise_valid_reg || !noise_stall)
            noise_valid_reg <= last_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!noise_valid_reg || !noise_stall)
            noise_value_reg <= sat_value;
    end

    assign noise_valid = noise_valid_reg;
    assign noise_value = noise_value_reg;

`ifndef NO_ASSERTIONS
    // the input side only backs up when the output is full and blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pt_stall |-> (noise_valid && noise_stall && last_valid))
        else $error("point stall without a blocked result");

    // a new result can only come out of the last cell
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(noise_valid) |-> $past(last_valid))
        else $error("result appeared without a finished item");

    // a taken result with nothing behind it leaves the output empty
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (noise_valid && !noise_stall && !last_valid) |=> !noise_valid)
        else $error("result repeated after transfer");
`endif

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

    import fgn_pkg::*;

    localparam int OCTAVES_MAX = 8;
    localparam int ANGLE_BITS  = 10;
    localparam int FRAC        = 16;
    localparam int LATENCY     = 10 * OCTAVES_MAX + 1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr = '0;
    logic [CFG_DATA_W-1:0]  pwdata = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    logic                   pt_valid = 1'b0;
    logic                   pt_stall;
    logic signed [31:0]     x_coord = '0;
    logic signed [31:0]     y_coord = '0;

    logic                   noise_valid;
    logic                   noise_stall = 1'b0;
    logic signed [OUT_W-1:0] noise_value;

    // Points waiting to be driven, and noise values waiting to come out.
    point_t                  point_fifo[$];
    logic signed [OUT_W-1:0] noise_due[$];

    // Gradient table, one entry per angle index, Q1.15.
    longint grad_x[1 << ANGLE_BITS];
    longint grad_y[1 << ANGLE_BITS];

    logic [3:0] octave_reg = 4'd1;
    bit         calm = 1'b0;
    int         gap_left = 0;
    int         stall_left = 0;
    int         mismatches = 0;
    int         points_sent = 0;
    int         noise_seen = 0;
    int         settings_run = 0;

    fractal_gradient_noise_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .pt_valid    (pt_valid),
        .pt_stall    (pt_stall),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .noise_valid (noise_valid),
        .noise_stall (noise_stall),
        .noise_value (noise_value)
    );

    always #5 clk = ~clk;

    // Arithmetic right shift on a signed value is a floor, so adding half an
    // LSB first rounds half toward plus infinity.
    function automatic longint round_half_up(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Polynomial cos/sin for 0 <= angle <= pi/4, angle and results in Q30.
    function automatic void octant_cos_sin(input logic [63:0] ang,
                                           output logic [63:0] c, output logic [63:0] s);
        logic [63:0] sq;
        logic [63:0] t;
        int sdiv[6];
        int cdiv[6];
        sdiv = '{156, 110, 72, 42, 20, 6};
        cdiv = '{132, 90, 56, 30, 12, 2};
        sq = (ang * ang + (64'd1 << 29)) >> 30;
        t = 64'd1 << 30;
        for (int i = 0; i < 6; i++)
            t = (64'd1 << 30) - ((sq * t) >> 30) / 64'(sdiv[i]);
        s = (ang * t) >> 30;
        t = 64'd1 << 30;
        for (int i = 0; i < 6; i++)
            t = (64'd1 << 30) - ((sq * t) >> 30) / 64'(cdiv[i]);
        c = t;
    endfunction

    function automatic longint to_q15(logic [63:0] v);
        return longint'((v + (64'd1 << 14)) >> 15);
    endfunction

    task automatic build_gradients();
        logic [63:0] c;
        logic [63:0] s;
        logic [63:0] n;
        longint gc;
        longint gs;
        int j;
        quad_t q;
        n = 64'd1 << ANGLE_BITS;
        for (int k = 0; k < (1 << ANGLE_BITS); k++)
        begin
            j = k & ((1 << (ANGLE_BITS - 2)) - 1);
            q = quad_t'((k >> (ANGLE_BITS - 2)) & 3);
            if (64'(j) <= (n >> 3))
            begin
                octant_cos_sin((64'(j) * TWO_PI_Q30) >> ANGLE_BITS, c, s);
                gc = to_q15(c);
                gs = to_q15(s);
            end
            else
            begin
                octant_cos_sin((((n >> 2) - 64'(j)) * TWO_PI_Q30) >> ANGLE_BITS, c, s);
                gc = to_q15(s);
                gs = to_q15(c);
            end
            case (q)
                QUAD_I:   begin grad_x[k] = gc;  grad_y[k] = gs;  end
                QUAD_II:  begin grad_x[k] = -gs; grad_y[k] = gc;  end
                QUAD_III: begin grad_x[k] = -gc; grad_y[k] = -gs; end
                default:  begin grad_x[k] = gs;  grad_y[k] = -gc; end
            endcase
        end
    endtask

    function automatic longint corner_grad_dot(logic [31:0] cx, logic [31:0] cy,
                                               longint dx, longint dy);
        logic [31:0] a;
        logic [31:0] b;
        int k;
        a = cx * HASH_K1;
        b = cy ^ {a[15:0], a[31:16]};
        b = b * HASH_K2;
        a = a ^ {b[15:0], b[31:16]};
        a = a * HASH_K3;
        k = int'(a >> (32 - ANGLE_BITS));
        return round_half_up(grad_x[k] * dx + grad_y[k] * dy, GRAD_BITS);
    endfunction

    function automatic longint fade_curve(longint t);
        longint one;
        longint w;
        one = longint'(1) << FRAC;
        w = round_half_up(t * (6 * t - 15 * one), FRAC) + 10 * one;
        w = round_half_up(w * t, FRAC);
        w = round_half_up(w * t, FRAC);
        w = round_half_up(w * t, FRAC);
        if (w < 0)
            w = 0;
        if (w > one)
            w = one;
        return w;
    endfunction

    function automatic longint lerp_q16(longint a, longint b, longint f);
        return a + round_half_up((b - a) * f, FRAC);
    endfunction

    function automatic longint octave_noise(logic [31:0] ux, logic [31:0] uy);
        logic [31:0] cx;
        logic [31:0] cy;
        longint fx;
        longint fy;
        longint sx;
        longint sy;
        longint one;
        one = longint'(1) << FRAC;
        cx = $signed(ux) >>> FRAC;
        cy = $signed(uy) >>> FRAC;
        fx = longint'(ux[FRAC-1:0]);
        fy = longint'(uy[FRAC-1:0]);
        sx = fade_curve(fx);
        sy = fade_curve(fy);
        return lerp_q16(
            lerp_q16(corner_grad_dot(cx, cy, fx, fy),
                     corner_grad_dot(cx + 32'd1, cy, fx - one, fy), sx),
            lerp_q16(corner_grad_dot(cx, cy + 32'd1, fx, fy - one),
                     corner_grad_dot(cx + 32'd1, cy + 32'd1, fx - one, fy - one), sx),
            sy);
    endfunction

    // Sum the octaves exactly with OCTAVES_MAX extra fraction bits, round once,
    // then saturate to Q2.16.
    function automatic logic signed [OUT_W-1:0] fbm_noise(point_t p, logic [3:0] count);
        longint acc;
        int n;
        acc = 0;
        n = (count > OCTAVES_MAX) ? OCTAVES_MAX : int'(count);
        for (int o = 0; o < n; o++)
            acc += octave_noise(p.x << o, p.y << o) * (longint'(1) << (OCTAVES_MAX - o));
        acc = round_half_up(acc, OCTAVES_MAX + FRAC - OUT_FRAC);
        if (acc > OUT_MAX)
            acc = OUT_MAX;
        if (acc < OUT_MIN)
            acc = OUT_MIN;
        return acc[OUT_W-1:0];
    endfunction

    // Point driver: hold the payload while stalled, draw an idle gap per point.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pt_valid && !pt_stall)
            begin
                noise_due.push_back(fbm_noise({x_coord, y_coord}, octave_reg));
                points_sent++;
            end
            if (!pt_valid || !pt_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    pt_valid <= 1'b0;
                end
                else if (point_fifo.size() > 0)
                begin
                    point_t p;
                    p = point_fifo.pop_front();
                    x_coord  <= p.x;
                    y_coord  <= p.y;
                    pt_valid <= 1'b1;
                    gap_left <= calm ? 0 : $urandom_range(0, 4);
                end
                else
                    pt_valid <= 1'b0;
            end
        end
    end

    // Noise monitor: compare each transfer with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (noise_valid && !noise_stall)
            begin
                noise_seen++;
                if (noise_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected noise transfer: value %0d", noise_value);
                end
                else
                begin
                    logic signed [OUT_W-1:0] want;
                    want = noise_due.pop_front();
                    if (want !== noise_value)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("noise mismatch: expected %0d, got %0d (octaves %0d)",
                                     want, noise_value, octave_reg);
                    end
                end
                stall_left = calm ? 0 : $urandom_range(0, 4);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                noise_stall <= 1'b1;
            end
            else
                noise_stall <= 1'b0;
        end
    end

    // Write one register through a setup phase and an access phase.
    task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == CFG_ADDR_W'(REG_OCTAVE_COUNT))
            octave_reg = data[3:0];
    endtask

    task automatic drain();
        while (!(point_fifo.size() == 0 && !pt_valid && noise_due.size() == 0))
            @(posedge clk);
        // Let the pipeline settle before touching the register.
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    // Mix of wide random points, points near the origin and cell corners.
    function automatic point_t random_point();
        point_t p;
        case ($urandom_range(0, 3))
            0: p = {32'($urandom), 32'($urandom)};
            1: p = {32'($signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000),
                    32'($signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000)};
            2: p = {32'($urandom) & 32'hFFFF_0000, 32'($urandom) & 32'hFFFF_0000};
            default: p = {32'($urandom) | 32'h0000_FFFF, 32'($urandom) & 32'hFFFF_8000};
        endcase
        return p;
    endfunction

    initial
    begin
        logic [3:0] settings[12];
        settings = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd4, 4'd9, 4'd2, 4'd7, 4'd3, 4'd5, 4'd6, 4'd8};
        build_gradients();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points at the reset setting, then again at full octaves:
        // field extremes, cell edges, half cells and the wrap of cell + 1.
        for (int pass = 0; pass < 2; pass++)
        begin
            point_fifo.push_back({32'sh0000_0000, 32'sh0000_0000});
            point_fifo.push_back({32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
            point_fifo.push_back({32'sh8000_0000, 32'sh8000_0000});
            point_fifo.push_back({32'sh7FFF_FFFF, 32'sh8000_0000});
            point_fifo.push_back({-32'sd1, -32'sd1});
            point_fifo.push_back({32'sh0000_8000, 32'sh0000_8000});
            point_fifo.push_back({32'sh0000_FFFF, 32'sh0001_0000});
            point_fifo.push_back({32'shFFFF_0000, 32'sh7FFF_0000});
            point_fifo.push_back({32'sh5555_5555, 32'shAAAA_AAAA});
            point_fifo.push_back({32'sh4000_0000, 32'shC000_0000});
            point_fifo.push_back({32'sh0003_4000, -32'sh0002_C000});
            drain();
            settings_run++;
            apb_write(CFG_ADDR_W'(REG_OCTAVE_COUNT), 32'hFFFF_FFF8);
        end

        // Writes outside the register map must leave octave_count alone.
        apb_write(CFG_ADDR_W'(4), 32'h0000_0003);
        apb_write(CFG_ADDR_W'(7), 32'hFFFF_FFFF);

        for (int ph = 0; ph < 12; ph++)
        begin
            apb_write(CFG_ADDR_W'(REG_OCTAVE_COUNT),
                      ($urandom & 32'hFFFF_FFF0) | 32'(settings[ph]));
            calm = (ph % 4 == 3);
            for (int half = 0; half < 2; half++)
            begin
                for (int i = 0; i < 60; i++)
                    point_fifo.push_back(random_point());
                // Hold the sender until every prediction has been met.
                while (!(point_fifo.size() == 0 && !pt_valid && noise_due.size() == 0))
                    @(posedge clk);
            end
            drain();
            settings_run++;
        end

        calm = 1'b0;
        drain();
        $display("%0d points sent, %0d noise values checked, %0d octave settings",
                 points_sent, noise_seen, settings_run);
        $display("octave counts from 0 to 15, random stalls and gaps, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && noise_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout: %0d predictions left", noise_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
design/fgn_pkg.sv
design/fgn_fade.sv
design/fgn_corner.sv
design/fgn_cell.sv
design/fractal_gradient_noise_top.sv
bench/tb.sv
